// ===== hw/rtl/ild_pkg.sv =====
// shared types, class table and lookup for the instruction length decoder
package ild_pkg;

	localparam int NumBytes  = 5;
	localparam int MaxPrefix = 4;

	localparam logic [7:0] ImmMask = 8'd7;
	localparam logic [7:0] ClsP    = 8'h08;
	localparam logic [7:0] ClsO    = 8'h10;
	localparam logic [7:0] ClsM    = 8'h20;
	localparam logic [7:0] ClsX    = 8'h00;

	localparam logic [1:0] ModReg    = 2'd3;
	localparam logic [1:0] ModNoDisp = 2'd0;
	localparam logic [1:0] ModDisp8  = 2'd1;
	localparam logic [1:0] ModDisp32 = 2'd2;
	localparam logic [2:0] RmSib     = 3'd4;
	localparam logic [2:0] RmAbs     = 3'd5;

	localparam logic [7:0] ClassTab [256] = '{
		// 0x00
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsO, ClsO,
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsO, ClsX,
		// 0x10
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsO, ClsO,
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsO, ClsO,
		// 0x20
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsP, ClsO,
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsP, ClsO,
		// 0x30
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsP, ClsO,
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd4, ClsP, ClsO,
		// 0x40
		ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO,
		ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO,
		// 0x50
		ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO,
		ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO,
		// 0x60
		ClsO, ClsO, ClsO|ClsM, ClsO|ClsM, ClsP, ClsP, ClsX, ClsX,
		ClsO|8'd4, ClsO|ClsM|8'd4, ClsO|8'd1, ClsO|ClsM|8'd1, ClsO, ClsO, ClsO, ClsO,
		// 0x70
		ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1,
		ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1,
		// 0x80
		ClsO|ClsM|8'd1, ClsO|ClsM|8'd4, ClsO|ClsM|8'd1, ClsO|ClsM|8'd1,
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM,
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM,
		// 0x90
		ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO,
		ClsO, ClsO, ClsX, ClsO, ClsO, ClsO, ClsO, ClsO,
		// 0xA0
		ClsO|8'd1, ClsO|8'd4, ClsO|8'd1, ClsO|8'd4, ClsO, ClsO, ClsO, ClsO,
		ClsO|8'd1, ClsO|8'd4, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO,
		// 0xB0
		ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1, ClsO|8'd1,
		ClsO|8'd4, ClsO|8'd4, ClsO|8'd4, ClsO|8'd4, ClsO|8'd4, ClsO|8'd4, ClsO|8'd4, ClsO|8'd4,
		// 0xC0
		ClsO|ClsM|8'd1, ClsO|ClsM|8'd1, ClsX, ClsO, ClsX, ClsX, ClsO|ClsM|8'd1, ClsO|ClsM|8'd4,
		ClsX, ClsX, ClsX, ClsX, ClsX, ClsX, ClsX, ClsX,
		// 0xD0
		ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|ClsM, ClsO|8'd1, ClsO|8'd1, ClsX, ClsX,
		ClsX, ClsX, ClsX, ClsX, ClsX, ClsX, ClsX, ClsX,
		// 0xE0
		ClsX, ClsX, ClsX, ClsX, ClsX, ClsX, ClsX, ClsX,
		ClsX, ClsO|8'd4, ClsX, ClsO|8'd1, ClsX, ClsX, ClsX, ClsX,
		// 0xF0
		ClsP, ClsX, ClsP, ClsP, ClsO, ClsO, ClsO|ClsM|8'd1, ClsO|ClsM|8'd4,
		ClsO, ClsO, ClsO, ClsO, ClsO, ClsO, ClsO|ClsM, ClsO|ClsM
	};

	typedef struct packed {
		logic       pfx;
		logic       opc;
		logic       mrm;
		logic [2:0] imm;
	} cls_t;

	typedef logic [NumBytes-1:0][7:0] win_t;

	typedef struct packed {
		win_t                      win;
		cls_t [MaxPrefix-1:0]      cls;
	} s1_t;

	typedef struct packed {
		logic [2:0] pos;
		logic [7:0] opcode;
		logic [7:0] modrm;
		cls_t       cls;
	} s2_t;

	typedef struct packed {
		logic [3:0] len;
		logic [7:0] opcode;
		logic       ok;
	} s3_t;

	function automatic cls_t class_of(input logic [7:0] b);
		logic [7:0] raw;
		cls_t       c;
		raw   = ClassTab[b];
		c.pfx = (raw & ClsP) != 8'd0;
		c.opc = (raw & ClsO) != 8'd0;
		c.mrm = (raw & ClsM) != 8'd0;
		c.imm = raw[2:0] & ImmMask[2:0];
		return c;
	endfunction

endpackage

// ===== hw/rtl/ild_in_if.sv =====
// input channel: five-byte instruction window
interface ild_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_at_0;
	logic [7:0] byte_at_1;
	logic [7:0] byte_at_2;
	logic [7:0] byte_at_3;
	logic [7:0] byte_at_4;

	modport source (output valid, byte_at_0, byte_at_1, byte_at_2, byte_at_3, byte_at_4,
		input ready);
	modport sink (input valid, byte_at_0, byte_at_1, byte_at_2, byte_at_3, byte_at_4,
		output ready);
endinterface

// ===== hw/rtl/ild_out_if.sv =====
// output channel: decoded length and opcode
interface ild_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] insn_length;
	logic [7:0] op_byte;
	logic       decoded_ok;

	modport source (output valid, insn_length, op_byte, decoded_ok, input ready);
	modport sink (input valid, insn_length, op_byte, decoded_ok, output ready);
endinterface

// ===== hw/rtl/ild_classify.sv =====
// stage 1: table lookup of the first four bytes
module ild_classify (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  ild_pkg::win_t   up_win,
	output logic            valid_s1,
	input  logic            dn_ready,
	output ild_pkg::s1_t    data_s1
);
	import ild_pkg::*;

	s1_t nxt;

	always_comb begin
		nxt.win = up_win;
		for (int i = 0; i < MaxPrefix; i++) begin
			nxt.cls[i] = class_of(up_win[i]);
		end
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== hw/rtl/ild_locate.sv =====
// stage 2: prefix skip, opcode and modrm selection
module ild_locate (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  ild_pkg::s1_t    up_data,
	output logic            valid_s2,
	input  logic            dn_ready,
	output ild_pkg::s2_t    data_s2
);
	import ild_pkg::*;

	s2_t nxt;

	always_comb begin
		priority if (!up_data.cls[0].pfx) begin
			nxt.pos    = 3'd0;
			nxt.cls    = up_data.cls[0];
			nxt.opcode = up_data.win[0];
			nxt.modrm  = up_data.win[1];
		end else if (!up_data.cls[1].pfx) begin
			nxt.pos    = 3'd1;
			nxt.cls    = up_data.cls[1];
			nxt.opcode = up_data.win[1];
			nxt.modrm  = up_data.win[2];
		end else if (!up_data.cls[2].pfx) begin
			nxt.pos    = 3'd2;
			nxt.cls    = up_data.cls[2];
			nxt.opcode = up_data.win[2];
			nxt.modrm  = up_data.win[3];
		end else if (!up_data.cls[3].pfx) begin
			nxt.pos    = 3'd3;
			nxt.cls    = up_data.cls[3];
			nxt.opcode = up_data.win[3];
			nxt.modrm  = up_data.win[4];
		end else begin
			nxt.pos    = 3'd4;
			nxt.cls    = up_data.cls[3];
			nxt.opcode = up_data.win[3];
			nxt.modrm  = up_data.win[4];
		end
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s2 <= nxt;
		end
	end

	// four prefixes leave a prefix class, which never decodes
	a_all_prefix_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2.pos == 3'd4 |-> !data_s2.cls.opc)
		else $error("four prefixes carried a valid opcode class");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> data_s2.pos <= 3'd4)
		else $error("prefix count out of range");

endmodule

// ===== hw/rtl/ild_length.sv =====
// stage 3: modrm, sib and displacement sizing, final length
module ild_length (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  ild_pkg::s2_t    up_data,
	output logic            valid_s3,
	input  logic            dn_ready,
	output ild_pkg::s3_t    data_s3
);
	import ild_pkg::*;

	s3_t        nxt;
	logic [1:0] mod;
	logic [2:0] rm;
	logic [3:0] addr_len;
	logic [3:0] disp_len;
	logic [3:0] sib_len;

	always_comb begin
		mod      = up_data.modrm[7:6];
		rm       = up_data.modrm[2:0];
		sib_len  = 4'd0;
		disp_len = 4'd0;
		if (mod != ModReg) begin
			if (rm == RmSib) begin
				sib_len = 4'd1;
			end
			if (mod == ModNoDisp && rm == RmAbs) begin
				disp_len = 4'd4;
			end else if (mod == ModDisp8) begin
				disp_len = 4'd1;
			end else if (mod == ModDisp32) begin
				disp_len = 4'd4;
			end
		end
		addr_len = up_data.cls.mrm ? (4'd1 + sib_len + disp_len) : 4'd0;
		nxt.opcode = up_data.opcode;
		if (up_data.cls.opc) begin
			nxt.len = {1'b0, up_data.pos} + 4'd1 + addr_len + {1'b0, up_data.cls.imm};
		end else begin
			nxt.len = 4'd0;
		end
		nxt.ok = up_data.cls.opc;
	end

	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s3 <= nxt;
		end
	end

	a_ok_matches_len: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (data_s3.ok == (data_s3.len != 4'd0)))
		else $error("decoded flag disagrees with length");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> data_s3.len <= 4'd14)
		else $error("length exceeds longest encoding");

endmodule

// ===== hw/rtl/x86_insn_length_decoder_core.sv =====
// top level of the instruction length decoder
// throughput: one item per cycle while info.ready is high; each stage register frees as its successor takes
// stalls: info.ready back-pressures all three stages, bubbles are collapsed
// reset: arst_n clears the stage valid bits only, no table or memory to clear
module x86_insn_length_decoder_core (
	input  logic           clk,
	input  logic           arst_n,
	ild_in_if.sink         insn,
	ild_out_if.source      info
);
	import ild_pkg::*;

	win_t win;
	s1_t  data_s1;
	s2_t  data_s2;
	s3_t  data_s3;
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic ready_s1;
	logic ready_s2;

	assign win = {insn.byte_at_4, insn.byte_at_3, insn.byte_at_2, insn.byte_at_1,
		insn.byte_at_0};

	ild_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (insn.valid),
		.up_ready (insn.ready),
		.up_win   (win),
		.valid_s1 (valid_s1),
		.dn_ready (ready_s1),
		.data_s1  (data_s1)
	);

	ild_locate u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_ready (ready_s1),
		.up_data  (data_s1),
		.valid_s2 (valid_s2),
		.dn_ready (ready_s2),
		.data_s2  (data_s2)
	);

	ild_length u_length (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s2),
		.up_ready (ready_s2),
		.up_data  (data_s2),
		.valid_s3 (valid_s3),
		.dn_ready (info.ready),
		.data_s3  (data_s3)
	);

	assign info.valid       = valid_s3;
	assign info.insn_length = data_s3.len;
	assign info.op_byte     = data_s3.opcode;
	assign info.decoded_ok  = data_s3.ok;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		insn.valid && insn.ready |=> valid_s1)
		else $error("accepted item did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(data_s1))
		else $error("stalled stage 1 item changed");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s2 |=> valid_s2 && $stable(data_s2))
		else $error("stalled stage 2 item changed");

endmodule

// ===== verif/ild_length_checker.sv =====
// checker for the instruction length decoder: predicts each decode and compares results
module ild_length_checker (
	input  logic clk,
	input  logic arst_n,
	ild_in_if    insn,
	ild_out_if   info,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ModNoDisp = 2'd0;
	localparam logic [1:0] ModDisp8  = 2'd1;
	localparam logic [1:0] ModDisp32 = 2'd2;
	localparam logic [1:0] ModReg    = 2'd3;
	localparam logic [2:0] RmSib     = 3'd4;
	localparam logic [2:0] RmAbs     = 3'd5;

	typedef struct packed {
		logic       pfx;
		logic       opc;
		logic       mrm;
		logic [2:0] imm;
	} byte_cls_t;

	typedef struct packed {
		logic [3:0] len;
		logic [7:0] opc;
		logic       ok;
	} decode_t;

	decode_t decodes [$];
	int      mismatches;

	function automatic byte_cls_t byte_class(input logic [7:0] b);
		byte_cls_t c;
		c.pfx = 1'b0;
		c.opc = 1'b1;
		c.mrm = 1'b0;
		c.imm = 3'd0;
		if (b < 8'h40) begin
			case (b[2:0])
				3'd0, 3'd1, 3'd2, 3'd3: c.mrm = 1'b1;
				3'd4: c.imm = 3'd1;
				3'd5: c.imm = 3'd4;
				default: ;
			endcase
		end
		case (b)
			8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF0, 8'hF2, 8'hF3: begin
				c.pfx = 1'b1;
				c.opc = 1'b0;
				c.mrm = 1'b0;
				c.imm = 3'd0;
			end
			8'h0F, 8'h66, 8'h67, 8'h9A, 8'hC2, 8'hC4, 8'hC5, 8'hC8, 8'hC9, 8'hCA,
			8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA,
			8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4,
			8'hE5, 8'hE6, 8'hE7, 8'hE8, 8'hEA, 8'hEC, 8'hED, 8'hEE, 8'hEF,
			8'hF1: c.opc = 1'b0;
			8'h62, 8'h63, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
			8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hFE,
			8'hFF: c.mrm = 1'b1;
			8'h69, 8'h81, 8'hC7, 8'hF7: begin
				c.mrm = 1'b1;
				c.imm = 3'd4;
			end
			8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6, 8'hF6: begin
				c.mrm = 1'b1;
				c.imm = 3'd1;
			end
			8'h68, 8'hA1, 8'hA3, 8'hA9, 8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD,
			8'hBE, 8'hBF, 8'hE9: c.imm = 3'd4;
			8'h6A, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
			8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F, 8'hA0, 8'hA2, 8'hA8,
			8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hD4, 8'hD5,
			8'hEB: c.imm = 3'd1;
			default: ;
		endcase
		return c;
	endfunction

	function automatic decode_t decode_length(input logic [4:0][7:0] w);
		byte_cls_t  c;
		decode_t    d;
		logic [7:0] modrm;
		int         pos;
		bit         found;
		c     = '0;
		d     = '0;
		pos   = 0;
		found = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (!found) begin
				d.opc = w[i];
				c     = byte_class(w[i]);
				pos   = i;
				if (!c.pfx)
					found = 1'b1;
			end
		end
		// four prefixes leave a prefix class here, which is not an opcode
		if (c.opc) begin
			if (c.mrm) begin
				pos++;
				modrm = w[pos];
				if (modrm[7:6] != ModReg) begin
					if (modrm[2:0] == RmSib)
						pos++;
					if (modrm[7:6] == ModNoDisp && modrm[2:0] == RmAbs)
						pos += 4;
					else if (modrm[7:6] == ModDisp8)
						pos += 1;
					else if (modrm[7:6] == ModDisp32)
						pos += 4;
				end
			end
			d.len = 4'(pos + 1 + int'(c.imm));
		end else begin
			d.len = 4'd0;
		end
		d.ok = d.len != 4'd0;
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decode_t want;
		if (!arst_n) begin
			decodes.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (insn.valid && insn.ready)
				decodes.push_back(decode_length({insn.byte_at_4, insn.byte_at_3,
					insn.byte_at_2, insn.byte_at_1, insn.byte_at_0}));
			if (info.valid && info.ready) begin
				if (decodes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: len %0d opcode %h ok %b",
							info.insn_length, info.op_byte, info.decoded_ok);
				end else begin
					want = decodes.pop_front();
					if (info.insn_length !== want.len || info.op_byte !== want.opc ||
						info.decoded_ok !== want.ok) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp len %0d opc %h ok %b, got %0d %h %b",
								want.len, want.opc, want.ok,
								info.insn_length, info.op_byte, info.decoded_ok);
					end
				end
			end
			fail_count <= mismatches;
			pending    <= decodes.size();
		end
	end

endmodule

// ===== verif/x86_insn_length_decoder_core_tb.sv =====
// testbench top for the instruction length decoder: stimulus, back-pressure and verdict
module x86_insn_length_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   calm;

	localparam logic [7:0] PrefixBytes [9] = '{8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
		8'hF0, 8'hF2, 8'hF3};

	ild_in_if  insn_ch ();
	ild_out_if info_ch ();

	x86_insn_length_decoder_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.insn   (insn_ch),
		.info   (info_ch)
	);

	ild_length_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.insn       (insn_ch),
		.info       (info_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("[x86_insn_length_decoder_core] ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			insn_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		insn_ch.valid     <= 1'b1;
		insn_ch.byte_at_0 <= b0;
		insn_ch.byte_at_1 <= b1;
		insn_ch.byte_at_2 <= b2;
		insn_ch.byte_at_3 <= b3;
		insn_ch.byte_at_4 <= b4;
		@(posedge clk);
		while (!insn_ch.ready) @(posedge clk);
	endtask

	task automatic send_random(input bit shaped);
		logic [7:0] b [5];
		logic [2:0] rm;
		int         np;
		int         r;
		for (int i = 0; i < 5; i++)
			b[i] = 8'($urandom_range(0, 255));
		if (shaped) begin
			r  = $urandom_range(0, 15);
			np = (r < 5) ? 0 : (r < 9) ? 1 : (r < 12) ? 2 : (r < 15) ? 3 : 4;
			for (int i = 0; i < np; i++)
				b[i] = PrefixBytes[$urandom_range(0, 8)];
			if (np < 4 && $urandom_range(0, 1) == 1) begin
				r  = $urandom_range(0, 2);
				rm = (r == 0) ? 3'd4 : (r == 1) ? 3'd5 : 3'($urandom_range(0, 7));
				b[np+1] = {2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rm};
			end
		end
		send_bytes(b[0], b[1], b[2], b[3], b[4]);
	endtask

	// receiver: runs of ready with random stalls between them
	initial begin
		int run;
		int stall;
		info_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			run = $urandom_range(1, 20);
			info_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				info_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		calm              = 1'b0;
		arst_n            = 1'b0;
		insn_ch.valid     = 1'b0;
		insn_ch.byte_at_0 = 8'h00;
		insn_ch.byte_at_1 = 8'h00;
		insn_ch.byte_at_2 = 8'h00;
		insn_ch.byte_at_3 = 8'h00;
		insn_ch.byte_at_4 = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_bytes(8'h0F, 8'h12, 8'h34, 8'h56, 8'h78);
		send_bytes(8'h26, 8'h2E, 8'h36, 8'h3E, 8'h90);
		send_bytes(8'hF0, 8'hF2, 8'hF3, 8'h64, 8'h65);
		send_bytes(8'hF0, 8'hF2, 8'hF3, 8'h81, 8'h84);
		send_bytes(8'h8B, 8'h05, 8'h11, 8'h22, 8'h33);
		send_bytes(8'h8B, 8'h45, 8'h08, 8'h00, 8'h00);
		send_bytes(8'h8B, 8'h44, 8'h24, 8'h08, 8'h00);
		send_bytes(8'h8B, 8'h84, 8'h25, 8'h00, 8'h00);
		send_bytes(8'h8B, 8'hC4, 8'h00, 8'h00, 8'h00);
		send_bytes(8'h8B, 8'h04, 8'h25, 8'h00, 8'h00);
		send_bytes(8'h8B, 8'h85, 8'h00, 8'h00, 8'h00);
		send_bytes(8'h04, 8'h7F, 8'h00, 8'h00, 8'h00);
		send_bytes(8'h05, 8'h01, 8'h02, 8'h03, 8'h04);
		send_bytes(8'h90, 8'hAA, 8'h55, 8'hAA, 8'h55);
		send_bytes(8'h66, 8'h90, 8'h00, 8'h00, 8'h00);
		send_bytes(8'h26, 8'h0F, 8'h00, 8'h00, 8'h00);
		send_bytes(8'hF6, 8'h05, 8'h00, 8'h00, 8'h00);
		send_bytes(8'hC7, 8'h04, 8'h24, 8'h00, 8'h00);
		send_bytes(8'h64, 8'h65, 8'hF0, 8'hE9, 8'h00);
		send_bytes(8'h62, 8'h00, 8'h00, 8'h00, 8'h00);
		send_bytes(8'h3E, 8'h36, 8'h69, 8'h44, 8'h00);
		send_bytes(8'hF3, 8'hF1, 8'h00, 8'h00, 8'h00);

		for (int k = 0; k < 4; k++) begin
			calm = (k == 2);
			repeat (500) send_random($urandom_range(0, 3) != 0);
			if (k == 1) begin
				insn_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		calm = 1'b0;

		insn_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[x86_insn_length_decoder_core] OK");
		else
			$display("[x86_insn_length_decoder_core] ERROR");
		$finish;
	end

endmodule
